// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Field widths, status codes and the command bundle sent to every cell.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int M_TDATA_W  = 72;  // 32 + 32 + 7 = 71, filled up to 9 bytes
    localparam int M_TDATA_PAD = M_TDATA_W - 2 * DATA_W - COUNT_W;

    // Operation selector carried on s_tuser.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status carried on m_tuser.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Command broadcast to all cells in the cycle a transaction is taken.
    typedef struct packed {
        logic ins;  // insert the broadcast value
        logic rem;  // shift every entry one cell toward the head
    } cell_cmd_t;

endpackage : mhpq_pkg

// ===== rtl/mhpq_cell.sv =====
// ----------------------------------------------------------------------------
// mhpq_cell: one storage cell of the sorted queue chain
// Holds one entry and its valid bit; trades entries with its two neighbors.
// ----------------------------------------------------------------------------
module mhpq_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mhpq_pkg::cell_cmd_t               cmd,
    input  logic signed [mhpq_pkg::DATA_W-1:0] ins_val,
    input  logic                              prev_keep,
    input  logic signed [mhpq_pkg::DATA_W-1:0] prev_val,
    input  logic                              prev_vld,
    input  logic signed [mhpq_pkg::DATA_W-1:0] next_val,
    input  logic                              next_vld,
    output logic signed [mhpq_pkg::DATA_W-1:0] val_o,
    output logic                              vld_o,
    output logic                              keep_o
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     vld_reg;
    logic                     vld_next;

    // The entry stays put on insert when it is at least the new value.
    assign keep_o = vld_reg && (val_reg >= ins_val);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (cmd.ins) begin
            if (!keep_o) begin
                // The first cell that does not keep takes the new value,
                // every later one takes what its predecessor held.
                val_next = prev_keep ? ins_val : prev_val;
                vld_next = vld_reg | prev_vld;
            end
        end else if (cmd.rem) begin
            val_next = next_val;
            vld_next = next_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign val_o = val_reg;
    assign vld_o = vld_reg;

endmodule : mhpq_cell

// ===== rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue: priority queue of signed 32-bit values
// Output: the result of a transaction is registered and is on m_* in the cycle after it is taken.
// One transaction per cycle (one compare per cell) unless m_tready stalls.
// Reset: aresetn low empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] mode (0 insert, 1 remove maximum)
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata,
                                   // [31:0] removed_value, [63:32] top_value,
                                   // [70:64] entry_count, [71] zero
    output logic [mhpq_pkg::STATUS_W-1:0]  m_tuser  // [1:0] status
);
    import mhpq_pkg::*;

    // The queue is kept as a chain of cells sorted from the largest value at
    // cell 0 down, with valid entries forming an unbroken prefix. The outputs
    // depend only on the set of values held, so this order answers exactly
    // like a binary heap: the maximum is always in cell 0.
    // Insert: every cell compares the new value with its own entry in the
    // same cycle; cells holding larger or equal values keep them, the first
    // smaller one takes the new value and the rest shift one cell down.
    // Remove: every cell takes the entry of its successor.

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                     s_acc;
    logic                     is_remove;
    logic signed [DATA_W-1:0] in_val;
    logic                     full;
    logic                     empty;
    cell_cmd_t                cmd;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic signed [DATA_W-1:0] val_c [CAPACITY+1];
    logic [CAPACITY:0]        vld_c;
    logic [CAPACITY:0]        keep_c;

    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic signed [DATA_W-1:0] top_next;
    logic [STATUS_W-1:0]      status_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [STATUS_W-1:0]      m_tuser_reg;

    // A new transaction is taken whenever the output register is free or
    // is being emptied in the same cycle.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;
    assign is_remove = (s_tuser[0] == MODE_REMOVE);
    assign in_val    = $signed(s_tdata);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign cmd.ins = s_acc && !is_remove && !full;
    assign cmd.rem = s_acc && is_remove && !empty;

    // Chain boundaries: the head sees a virtual neighbor that always keeps,
    // the tail sees an empty slot behind it.
    assign keep_c[0]          = 1'b1;
    assign val_c[CAPACITY]    = '0;
    assign vld_c[CAPACITY]    = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] prev_val;
        logic                     prev_vld;

        if (i == 0) begin : g_head
            assign prev_val = in_val;
            assign prev_vld = 1'b1;
        end else begin : g_body
            assign prev_val = val_c[i-1];
            assign prev_vld = vld_c[i-1];
        end

        mhpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .ins_val   (in_val),
            .prev_keep (keep_c[i]),
            .prev_val  (prev_val),
            .prev_vld  (prev_vld),
            .next_val  (val_c[i+1]),
            .next_vld  (vld_c[i+1]),
            .val_o     (val_c[i]),
            .vld_o     (vld_c[i]),
            .keep_o    (keep_c[i+1])
        );
    end

    // Result fields, computed from the cell contents before they update.
    always_comb begin
        count_next   = count_reg;
        removed_next = '0;
        top_next     = vld_c[0] ? val_c[0] : '0;
        status_next  = STATUS_OK;
        if (!is_remove) begin
            if (full) begin
                status_next = STATUS_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
                top_next   = keep_c[1] ? val_c[0] : in_val;
            end
        end else begin
            if (empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = val_c[0];
                top_next     = vld_c[1] ? val_c[1] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_acc) begin
            m_tdata_reg <= {{M_TDATA_PAD{1'b0}}, COUNT_W'(count_next),
                            top_next, removed_next};
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // The entry count always matches the number of occupied cells.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vld_c[CAPACITY-1:0]) == count_reg)
        else $error("entry count differs from occupied cells");

    // Occupied cells form an unbroken run starting at the head.
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_c[CAPACITY-1:0] & (vld_c[CAPACITY-1:0] + 1'b1)) == '0)
        else $error("hole in the occupied cells");

    // The head is never smaller than the entry in cell 1.
    a_head_max: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_c[1] |-> (val_c[0] >= val_c[1]))
        else $error("head is not the maximum");

    // An insert into a full queue reports the full status.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_remove && full) |=> (m_tuser == STATUS_FULL))
        else $error("insert on full not flagged");
`endif

endmodule : max_heap_priority_queue
